// ===== hdl/kat_pkg.sv =====
// Shared types and codes for the keyed alarm table.
package kat_pkg;

   typedef struct packed {
      logic [2:0]         mode;
      logic [15:0]        alarm_code;
      logic signed [31:0] alarm_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] found_value;
      logic [15:0]        entry_key;
      logic [4:0]         removed_count;
      logic [4:0]         used_count;
      logic               last_flag;
   } rsp_type;

   // request mode codes
   localparam logic [2:0] MODE_ADD        = 3'd0;
   localparam logic [2:0] MODE_FIND       = 3'd1;
   localparam logic [2:0] MODE_UPDATE     = 3'd2;
   localparam logic [2:0] MODE_REMOVE     = 3'd3;
   localparam logic [2:0] MODE_REMOVE_ALL = 3'd4;
   localparam logic [2:0] MODE_DUMP       = 3'd5;
   localparam logic [2:0] MODE_CLEAR      = 3'd6;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // decoded operation carried from front to back
   typedef enum logic [2:0] {
      OP_ADD, OP_FIND, OP_UPDATE, OP_REMOVE, OP_REMOVE_ALL, OP_DUMP, OP_CLEAR, OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [15:0]        code;
      logic signed [31:0] value;
   } cmd_type;

endpackage

// ===== hdl/keyed_alarm_table.sv =====
// Keyed alarm table: ordered list of (code, value) entries, newest first.
//
// Request channel (req_valid / req_stall / req_data) carries one command per
// transaction: add, find, update, remove, remove all, dump or clear. Results
// leave on the response channel (rsp_valid / rsp_stall / rsp_data); every
// command gives one result except dump, which gives one per entry (none when
// empty) with last_flag on the final one.
// A two-entry queue sits between decode and execution, so requests keep
// flowing while the back end works or the response side stalls.
// Single-result commands pass through dequeue, parallel key compare and
// execute before the result is registered. Remove all repeats the compare
// and execute for each deleted entry; dump results leave one per cycle
// while the response side does not stall. The back end takes a new command
// only after the last one is done.
// Reset empties the table, the command queue and the output register. A
// stalled response holds its payload; the back end waits on the output
// register and the queue fills, after which req_stall rises.
module keyed_alarm_table
   import kat_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    f_valid, f_stall;
   cmd_type f_cmd;
   logic    q_valid, q_pop;
   cmd_type q_cmd;

   // decode requests
   kat_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (f_valid),
      .cmd_stall (f_stall),
      .cmd_data  (f_cmd)
   );

   // decouple decode from execution
   kat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_stall  (f_stall),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_cmd   (q_cmd)
   );

   // execute against the table
   kat_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_pop   (q_pop),
      .cmd_data  (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/kat_front.sv =====
// Front end: accepts request transactions and decodes them into commands.
module kat_front
   import kat_pkg::*;
(
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_stall,
   output cmd_type cmd_data
);

   op_type op;

   // decode the mode field; the unused code becomes a no-op
   always_comb begin
      unique case (req_data.mode)
         MODE_ADD:        op = OP_ADD;
         MODE_FIND:       op = OP_FIND;
         MODE_UPDATE:     op = OP_UPDATE;
         MODE_REMOVE:     op = OP_REMOVE;
         MODE_REMOVE_ALL: op = OP_REMOVE_ALL;
         MODE_DUMP:       op = OP_DUMP;
         MODE_CLEAR:      op = OP_CLEAR;
         default:         op = OP_NOP;
      endcase
   end

   // forward the decoded command toward the queue
   assign cmd_valid      = req_valid;
   assign req_stall      = cmd_stall;
   assign cmd_data.op    = op;
   assign cmd_data.code  = req_data.alarm_code;
   assign cmd_data.value = req_data.alarm_value;

endmodule

// ===== hdl/kat_queue.sv =====
// Two-entry command queue between the front end and the back end.
module kat_queue
   import kat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_pop,
   output cmd_type out_cmd
);

   cmd_type    mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = mem[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_pop && out_valid;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the incoming transaction
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== hdl/kat_back.sv =====
// Back end: holds the ordered entry list, executes commands, drives results.
module kat_back
   import kat_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int OW = $clog2(CAPACITY + 1);
   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_EXEC   = 4'b0100,
      ST_DUMP   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic               hit_ff, hit_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [PW-1:0]      idx_ff, idx_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [OW-1:0]      occ_ff, occ_in;
   logic [15:0]        key_ff [CAPACITY];
   logic [15:0]        key_in [CAPACITY];
   logic signed [31:0] data_ff [CAPACITY];
   logic signed [31:0] data_in [CAPACITY];
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [CAPACITY-1:0] match;
   logic [PW-1:0]       match_pos;
   logic                out_free;
   logic                emit;
   logic                full;
   rsp_type             rsp_new;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (occ_ff == OW'(CAPACITY));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // compare every occupied slot and pick the newest match
   always_comb begin
      match_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = (key_ff[i] == cmd_ff.code) && (occ_ff > OW'(i));
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_pos = PW'(i);
         end
      end
   end

   // sequence one command
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      hit_in   = hit_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      occ_in   = occ_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      cmd_pop  = 1'b0;
      emit     = 1'b0;
      rsp_new  = '0;
      rsp_new.status    = STATUS_OK;
      rsp_new.last_flag = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               cnt_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            hit_in   = |match;
            pos_in   = match_pos;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (cmd_ff.op)
               OP_ADD: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (full) begin
                        rsp_new.status = STATUS_FULL;
                     end else begin
                        for (int i = 1; i < CAPACITY; i++) begin
                           key_in[i]  = key_ff[i-1];
                           data_in[i] = data_ff[i-1];
                        end
                        key_in[0]  = cmd_ff.code;
                        data_in[0] = cmd_ff.value;
                        occ_in     = occ_ff + OW'(1);
                     end
                  end
               end
               OP_FIND, OP_UPDATE, OP_REMOVE: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (!hit_ff) begin
                        rsp_new.status = STATUS_NOT_FOUND;
                     end else if (cmd_ff.op == OP_FIND) begin
                        rsp_new.found_value = data_ff[pos_ff];
                     end else if (cmd_ff.op == OP_UPDATE) begin
                        data_in[pos_ff] = cmd_ff.value;
                     end else begin
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                           if (PW'(i) >= pos_ff) begin
                              key_in[i]  = key_ff[i+1];
                              data_in[i] = data_ff[i+1];
                           end
                        end
                        occ_in = occ_ff - OW'(1);
                     end
                  end
               end
               OP_REMOVE_ALL: begin
                  if (hit_ff) begin
                     // drop one match, then search again
                     for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (PW'(i) >= pos_ff) begin
                           key_in[i]  = key_ff[i+1];
                           data_in[i] = data_ff[i+1];
                        end
                     end
                     occ_in   = occ_ff - OW'(1);
                     cnt_in   = cnt_ff + 5'd1;
                     state_in = ST_SEARCH;
                  end else if (out_free) begin
                     emit                  = 1'b1;
                     rsp_new.removed_count = cnt_ff;
                     state_in              = ST_IDLE;
                  end
               end
               OP_DUMP: begin
                  idx_in   = '0;
                  state_in = (occ_ff == '0) ? ST_IDLE : ST_DUMP;
               end
               OP_CLEAR: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     occ_in   = '0;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_DUMP: begin
            if (out_free) begin
               emit                = 1'b1;
               rsp_new.found_value = data_ff[idx_ff];
               rsp_new.entry_key   = key_ff[idx_ff];
               rsp_new.last_flag   = (OW'(idx_ff) + OW'(1) == occ_ff);
               idx_in              = idx_ff + PW'(1);
               if (rsp_new.last_flag) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_new.used_count = 5'(occ_in);
   end

   // hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_new;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      hit_ff      <= hit_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      key_ff      <= key_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
